// ===== design/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants of the LCD window frame memory: access kinds,
// command codes, front-end modes and the request passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

  localparam int DEF_FRAME_WIDTH  = 240;
  localparam int DEF_FRAME_HEIGHT = 320;

  localparam int PIXEL_W = 16;
  localparam int CMD_W   = 2;
  // frame edge is at most 4096, so a cursor inside the frame fits 12 bits
  localparam int POS_W   = 12;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // access kinds on in_cmd
  localparam logic [CMD_W-1:0] KIND_CMD   = 2'd0;
  localparam logic [CMD_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] KIND_READ  = 2'd2;

  // command codes
  localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET   = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;
  localparam logic [7:0] CMD_MEM_READ   = 8'h2E;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_op_t;

  typedef struct packed {
    req_op_t            op;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [PIXEL_W-1:0] pixel;
  } req_t;

  // back-pressure seen by the front end
  typedef struct packed {
    logic clearing;
    logic queue_full;
  } hold_t;

endpackage

`default_nettype wire

// ===== design/lcdw_ram.sv =====
// ----------------------------------------------------------------------------
// lcdw_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/lcdw_front.sv =====
// ----------------------------------------------------------------------------
// lcdw_front
// Command decoder: tracks mode, window and cursor, and turns each request
// into a frame store write, a frame store read or a no-op for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_front #(
  parameter int FRAME_WIDTH  = 240,
  parameter int FRAME_HEIGHT = 320
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lcdw_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [lcdw_pkg::PIXEL_W-1:0] in_value,
  input  wire lcdw_pkg::hold_t              hold,
  output logic                              push,
  output lcdw_pkg::req_t                    req
);

  import lcdw_pkg::*;

  logic [7:0]  last_command_r, last_command_nxt;
  mode_t       mode_r, mode_nxt;
  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  byte_store_r [4];
  logic        byte_we;
  logic [15:0] col_first_r, col_first_nxt;
  logic [15:0] col_last_r, col_last_nxt;
  logic [15:0] row_first_r, row_first_nxt;
  logic [15:0] row_last_r, row_last_nxt;
  logic [15:0] cur_col_r, cur_col_nxt;
  logic [15:0] cur_row_r, cur_row_nxt;

  logic        accept;
  logic        in_frame;
  logic [15:0] col_inc, row_inc;
  logic [15:0] step_col, step_row;
  logic [15:0] win_lo, win_hi;

  assign in_stall = hold.clearing || hold.queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept;

  assign in_frame = (cur_col_r < 16'(FRAME_WIDTH)) && (cur_row_r < 16'(FRAME_HEIGHT));

  // cursor advance with wrap at column end, then at page end
  always_comb begin
    col_inc = cur_col_r + 16'd1;
    row_inc = cur_row_r + 16'd1;
    if (col_inc > col_last_r) begin
      step_col = col_first_r;
      step_row = (row_inc > row_last_r) ? row_first_r : row_inc;
    end else begin
      step_col = col_inc;
      step_row = cur_row_r;
    end
  end

  assign win_lo = {byte_store_r[0], byte_store_r[1]};
  assign win_hi = {byte_store_r[2], in_value[7:0]};

  always_comb begin
    last_command_nxt = last_command_r;
    mode_nxt         = mode_r;
    byte_count_nxt   = byte_count_r;
    byte_we          = 1'b0;
    col_first_nxt    = col_first_r;
    col_last_nxt     = col_last_r;
    row_first_nxt    = row_first_r;
    row_last_nxt     = row_last_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    req.op           = REQ_NONE;
    req.row          = cur_row_r[POS_W-1:0];
    req.col          = cur_col_r[POS_W-1:0];
    req.pixel        = in_value;
    if (accept) begin
      unique case (in_cmd)
        KIND_CMD: begin
          last_command_nxt = in_value[7:0];
          byte_count_nxt   = 3'd0;
          if (in_value[7:0] == CMD_MEM_WRITE || in_value[7:0] == CMD_MEM_READ) begin
            mode_nxt    = (in_value[7:0] == CMD_MEM_WRITE) ? MODE_WRITE : MODE_READ;
            cur_col_nxt = col_first_r;
            cur_row_nxt = row_first_r;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        KIND_WRITE: begin
          if (mode_r == MODE_WRITE) begin
            if (in_frame) begin
              req.op = REQ_WRITE;
            end
            cur_col_nxt = step_col;
            cur_row_nxt = step_row;
          end else if (last_command_r == CMD_COLUMN_SET ||
                       last_command_r == CMD_PAGE_SET) begin
            if (byte_count_r < 3'd4) begin
              byte_we        = 1'b1;
              byte_count_nxt = byte_count_r + 3'd1;
              if (byte_count_r == 3'd3) begin
                if (last_command_r == CMD_COLUMN_SET) begin
                  col_first_nxt = win_lo;
                  col_last_nxt  = win_hi;
                end else begin
                  row_first_nxt = win_lo;
                  row_last_nxt  = win_hi;
                end
              end
            end
          end
        end
        KIND_READ: begin
          if (mode_r == MODE_READ && in_frame) begin
            req.op      = REQ_READ;
            cur_col_nxt = step_col;
            cur_row_nxt = step_row;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_command_r <= 8'd0;
      mode_r         <= MODE_IDLE;
      byte_count_r   <= 3'd0;
      col_first_r    <= 16'd0;
      col_last_r     <= 16'd0;
      row_first_r    <= 16'd0;
      row_last_r     <= 16'd0;
      cur_col_r      <= 16'd0;
      cur_row_r      <= 16'd0;
    end else begin
      last_command_r <= last_command_nxt;
      mode_r         <= mode_nxt;
      byte_count_r   <= byte_count_nxt;
      col_first_r    <= col_first_nxt;
      col_last_r     <= col_last_nxt;
      row_first_r    <= row_first_nxt;
      row_last_r     <= row_last_nxt;
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
    end
  end

  // window bytes: always written before use within one collection
  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_store_r[byte_count_r[1:0]] <= in_value[7:0];
    end
  end

`ifndef SYNTHESIS
  a_byte_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= 3'd4)
    else $error("window byte count past four");

  a_mode_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_IDLE) |->
      (last_command_r == CMD_MEM_WRITE || last_command_r == CMD_MEM_READ))
    else $error("memory mode without memory command");
`endif

endmodule

`default_nettype wire

// ===== design/lcdw_queue.sv =====
// ----------------------------------------------------------------------------
// lcdw_queue
// Short request FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lcdw_pkg::req_t push_req,
  input  wire logic           pop,
  output logic                head_valid,
  output lcdw_pkg::req_t      head_req,
  output logic                full
);

  import lcdw_pkg::*;

  req_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_req   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== design/lcdw_back.sv =====
// ----------------------------------------------------------------------------
// lcdw_back
// Frame store side: address stage, memory access with registered read, and
// the result register. Runs the clearing pass over the frame after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdw_back #(
  parameter int FRAME_WIDTH  = 240,
  parameter int FRAME_HEIGHT = 320
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire lcdw_pkg::req_t               q_req,
  output logic                              q_pop,
  output logic                              clearing,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [lcdw_pkg::PIXEL_W-1:0] out_read_data,
  output logic                              out_pixel_stored
);

  import lcdw_pkg::*;

  localparam int FRAME_CELLS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W      = (FRAME_CELLS > 1) ? $clog2(FRAME_CELLS) : 1;

  logic              clearing_r, clearing_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic               s1_v_r, s1_v_nxt;
  req_op_t            s1_op_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic               s2_v_r, s2_v_nxt;
  req_op_t            s2_op_r;

  logic               s1_free, s2_free;
  logic               s1_go;
  logic [ADDR_W-1:0]  q_addr;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_addr;
  logic [PIXEL_W-1:0] ram_wdata, ram_rdata;

  assign clearing = clearing_r;

  assign s2_free = !s2_v_r || !out_stall;
  assign s1_free = !s1_v_r || s2_free;
  assign s1_go   = s1_v_r && s2_free;
  assign q_pop   = q_valid && s1_free;

  assign q_addr = ADDR_W'(q_req.row) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(q_req.col);

  always_comb begin
    s1_v_nxt     = s1_free ? q_valid : s1_v_r;
    s2_v_nxt     = s2_free ? s1_v_r : s2_v_r;
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      if (clr_addr_r == ADDR_W'(FRAME_CELLS - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_v_r     <= s1_v_nxt;
      s2_v_r     <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_op_r    <= q_req.op;
      s1_addr_r  <= q_addr;
      s1_pixel_r <= q_req.pixel;
    end
    if (s2_free) begin
      s2_op_r <= s1_op_r;
    end
  end

  // clearing pass owns the port; no request is in flight meanwhile
  always_comb begin
    ram_we    = clearing_r || (s1_go && s1_op_r == REQ_WRITE);
    ram_re    = !clearing_r && s1_go && s1_op_r == REQ_READ;
    ram_addr  = clearing_r ? clr_addr_r : s1_addr_r;
    ram_wdata = clearing_r ? '0 : s1_pixel_r;
  end

  lcdw_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (FRAME_CELLS)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // read data stays in the RAM output register while the result is stalled
  assign out_valid        = s2_v_r;
  assign out_read_data    = (s2_op_r == REQ_READ) ? ram_rdata : '0;
  assign out_pixel_stored = (s2_op_r == REQ_WRITE);

`ifndef SYNTHESIS
  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!s1_v_r && !s2_v_r && !q_valid))
    else $error("request in flight during clearing pass");

  a_addr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_op_r != REQ_NONE) |-> (s1_addr_r <= ADDR_W'(FRAME_CELLS - 1)))
    else $error("frame address out of range");
`endif

endmodule

`default_nettype wire

// ===== design/lcd_window_frame_memory.sv =====
// ----------------------------------------------------------------------------
// lcd_window_frame_memory
// Path: queue write, address stage, frame store access with registered read.
// Throughput: one request per cycle while out_stall is low, limited by the
//   single frame store port.
// Reset: synchronous; afterwards a clearing pass writes zero to all
//   FRAME_WIDTH*FRAME_HEIGHT cells, one per cycle, with in_stall held high.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_window_frame_memory #(
  parameter int FRAME_WIDTH  = lcdw_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = lcdw_pkg::DEF_FRAME_HEIGHT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lcdw_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [lcdw_pkg::PIXEL_W-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [lcdw_pkg::PIXEL_W-1:0] out_read_data,
  output logic                              out_pixel_stored
);

  import lcdw_pkg::*;

  hold_t hold;
  logic  push;
  req_t  push_req;
  logic  q_valid;
  req_t  q_req;
  logic  q_pop;
  logic  q_full;
  logic  clearing;

  assign hold.clearing   = clearing;
  assign hold.queue_full = q_full;

  lcdw_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_value (in_value),
    .hold     (hold),
    .push     (push),
    .req      (push_req)
  );

  lcdw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_req   (q_req),
    .full       (q_full)
  );

  lcdw_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_req            (q_req),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_pixel_stored (out_pixel_stored)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lcd_window_frame_memory. A queue of accesses
// (window setup, memory write/read bursts, noise and broken sequences)
// feeds a valid/stall driver. Each accepted access runs through a local
// model of the window, cursor and frame store, and the monitor matches
// every result against the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import lcdw_pkg::*;

  localparam int FRAME_W     = DEF_FRAME_WIDTH;
  localparam int FRAME_H     = DEF_FRAME_HEIGHT;
  localparam int FRAME_CELLS = FRAME_W * FRAME_H;

  localparam int DIRECTED_MAX = 30;
  localparam int RANDOM_ITEMS = 800;
  localparam int PHASE_LEN    = 200;
  localparam int DRAIN_AT     = 450;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;
  // clearing pass after reset writes the cells one per cycle
  localparam int WATCHDOG_MAX = 4 * FRAME_CELLS;

  // access kind 3 has no meaning for the block
  localparam logic [CMD_W-1:0] KIND_NONE = 2'd3;
  localparam logic [7:0]       CMD_OTHER = 8'h00;

  typedef enum logic [1:0] {
    PH_NONE     = 2'd0,
    PH_SENDER   = 2'd1,
    PH_RECEIVER = 2'd2,
    PH_BOTH     = 2'd3
  } idle_phase_t;

  typedef struct packed {
    logic [CMD_W-1:0]   kind;
    logic [PIXEL_W-1:0] value;
  } access_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] read_data;
    logic               pixel_stored;
  } pixel_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd = '0;
  logic [PIXEL_W-1:0]   in_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIXEL_W-1:0]   out_read_data;
  logic                 out_pixel_stored;

  lcd_window_frame_memory u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_pixel_stored (out_pixel_stored)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  access_t       access_q[$];
  pixel_result_t expected_q[$];
  int            total_items;
  int            issued;
  int            accepted;
  int            err_count;
  int            hold_left;
  bit            hold_done;
  int            idle_cycles;
  access_t       cur_access;
  access_t       next_access;
  pixel_result_t want;

  // model state
  logic [7:0]         m_last_cmd;
  mode_t              m_mode;
  logic [2:0]         m_byte_cnt;
  logic [7:0]         m_bytes [4];
  logic [PIXEL_W-1:0] m_col_first, m_col_last, m_row_first, m_row_last;
  logic [PIXEL_W-1:0] m_cur_col, m_cur_row;
  logic [PIXEL_W-1:0] frame_model [FRAME_CELLS];

  function automatic void reset_model();
    m_last_cmd  = '0;
    m_mode      = MODE_IDLE;
    m_byte_cnt  = '0;
    m_col_first = '0;
    m_col_last  = '0;
    m_row_first = '0;
    m_row_last  = '0;
    m_cur_col   = '0;
    m_cur_row   = '0;
    for (int i = 0; i < 4; i++) m_bytes[i] = '0;
    for (int i = 0; i < FRAME_CELLS; i++) frame_model[i] = '0;
  endfunction

  function automatic bit cursor_in_frame();
    return (int'(m_cur_col) < FRAME_W) && (int'(m_cur_row) < FRAME_H);
  endfunction

  function automatic int cursor_cell();
    return int'(m_cur_row) * FRAME_W + int'(m_cur_col);
  endfunction

  // 16-bit cursor: a window end of 0xFFFF never wraps
  function automatic void step_model_cursor();
    m_cur_col = m_cur_col + 16'd1;
    if (m_cur_col > m_col_last) begin
      m_cur_col = m_col_first;
      m_cur_row = m_cur_row + 16'd1;
      if (m_cur_row > m_row_last) m_cur_row = m_row_first;
    end
  endfunction

  function automatic pixel_result_t model_access(access_t acc);
    pixel_result_t res;
    logic [7:0]    op;
    res = '0;
    case (acc.kind)
      KIND_CMD: begin
        op = acc.value[7:0];
        m_last_cmd = op;
        m_byte_cnt = '0;
        if (op == CMD_MEM_WRITE || op == CMD_MEM_READ) begin
          if (op == CMD_MEM_WRITE) m_mode = MODE_WRITE;
          else m_mode = MODE_READ;
          m_cur_col = m_col_first;
          m_cur_row = m_row_first;
        end else begin
          m_mode = MODE_IDLE;
        end
      end
      KIND_WRITE: begin
        if (m_mode == MODE_WRITE) begin
          if (cursor_in_frame()) begin
            frame_model[cursor_cell()] = acc.value;
            res.pixel_stored = 1'b1;
          end
          step_model_cursor();
        end else if (m_last_cmd == CMD_COLUMN_SET || m_last_cmd == CMD_PAGE_SET) begin
          if (m_byte_cnt < 3'd4) begin
            m_bytes[m_byte_cnt[1:0]] = acc.value[7:0];
            m_byte_cnt = m_byte_cnt + 3'd1;
            if (m_byte_cnt == 3'd4) begin
              if (m_last_cmd == CMD_COLUMN_SET) begin
                m_col_first = {m_bytes[0], m_bytes[1]};
                m_col_last  = {m_bytes[2], m_bytes[3]};
              end else begin
                m_row_first = {m_bytes[0], m_bytes[1]};
                m_row_last  = {m_bytes[2], m_bytes[3]};
              end
            end
          end
        end
      end
      KIND_READ: begin
        if (m_mode == MODE_READ && cursor_in_frame()) begin
          res.read_data = frame_model[cursor_cell()];
          step_model_cursor();
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---- stimulus building ----
  task automatic queue_access(input logic [CMD_W-1:0] kind, input logic [PIXEL_W-1:0] value);
    access_t a;
    a.kind  = kind;
    a.value = value;
    access_q.push_back(a);
  endtask

  // command code in the low byte, junk above it
  task automatic queue_cmd(input logic [7:0] code);
    logic [PIXEL_W-1:0] v;
    v = PIXEL_W'($urandom);
    v[7:0] = code;
    queue_access(KIND_CMD, v);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    logic [PIXEL_W-1:0] v;
    v = PIXEL_W'($urandom);
    v[7:0] = b;
    queue_access(KIND_WRITE, v);
  endtask

  task automatic queue_window(input logic [7:0] code, input logic [15:0] lo,
                              input logic [15:0] hi);
    queue_cmd(code);
    queue_byte(lo[15:8]);
    queue_byte(lo[7:0]);
    queue_byte(hi[15:8]);
    queue_byte(hi[7:0]);
  endtask

  task automatic pick_span(input int span_max, output logic [15:0] lo, output logic [15:0] hi);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) begin
      lo = 16'($urandom_range(0, span_max - 1));
      hi = lo + 16'($urandom_range(0, 4));
    end else if (sel < 16) begin
      // straddles the frame edge
      lo = 16'(span_max - 1 - $urandom_range(0, 2));
      hi = 16'(span_max + $urandom_range(0, 2));
    end else if (sel == 16) begin
      lo = 16'($urandom_range(0, span_max - 1));
      hi = lo - 16'd1;
    end else if (sel == 17) begin
      lo = 16'($urandom_range(0, span_max - 1));
      hi = 16'hFFFF;
    end else if (sel == 18) begin
      lo = 16'hFFFF - 16'($urandom_range(0, 2));
      hi = 16'hFFFF;
    end else begin
      lo = 16'd0;
      hi = 16'(span_max - 1);
    end
  endtask

  function automatic logic [7:0] random_code();
    case ($urandom_range(0, 5))
      0: return CMD_COLUMN_SET;
      1: return CMD_PAGE_SET;
      2: return CMD_MEM_WRITE;
      3: return CMD_MEM_READ;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_noise(input int n);
    logic [CMD_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      k = CMD_W'($urandom_range(0, 3));
      if (k == KIND_CMD) queue_cmd(random_code());
      else queue_access(k, PIXEL_W'($urandom));
    end
  endtask

  task automatic queue_burst();
    logic [15:0] lo, hi;
    int n;
    if ($urandom_range(0, 9) != 0) begin
      pick_span(FRAME_W, lo, hi);
      queue_window(CMD_COLUMN_SET, lo, hi);
      pick_span(FRAME_H, lo, hi);
      queue_window(CMD_PAGE_SET, lo, hi);
    end
    n = $urandom_range(1, 16);
    queue_cmd(CMD_MEM_WRITE);
    for (int i = 0; i < n; i++) begin
      queue_access(KIND_WRITE, PIXEL_W'($urandom));
      if ($urandom_range(0, 15) == 0) queue_noise(1);
    end
    queue_cmd(CMD_MEM_READ);
    for (int i = 0; i < n + $urandom_range(0, 2); i++) queue_access(KIND_READ, PIXEL_W'($urandom));
  endtask

  // window setup with zero to six bytes, then a memory command and noise
  task automatic queue_broken();
    int nb;
    if ($urandom_range(0, 1) != 0) queue_cmd(CMD_COLUMN_SET);
    else queue_cmd(CMD_PAGE_SET);
    nb = $urandom_range(0, 6);
    for (int i = 0; i < nb; i++) queue_byte(8'($urandom));
    if ($urandom_range(0, 1) != 0) queue_cmd(CMD_MEM_WRITE);
    else queue_cmd(CMD_MEM_READ);
    queue_noise($urandom_range(1, 4));
  endtask

  task automatic build_directed();
    queue_access(KIND_READ, 16'hFFFF);     // read in idle
    queue_access(KIND_WRITE, 16'hFFFF);    // write in idle
    queue_access(KIND_NONE, 16'hFFFF);
    queue_access(KIND_CMD, {8'hFF, CMD_MEM_WRITE});
    queue_access(KIND_WRITE, 16'hFFFF);    // one-cell window wraps onto itself
    queue_access(KIND_WRITE, 16'h0000);
    queue_access(KIND_CMD, {8'h00, CMD_MEM_READ});
    queue_access(KIND_READ, 16'h0000);
    queue_window(CMD_COLUMN_SET, 16'hFFFE, 16'hFFFF);
    queue_access(KIND_WRITE, 16'h5A5A);    // surplus byte ignored
    queue_cmd(CMD_MEM_WRITE);
    queue_access(KIND_WRITE, 16'h1234);    // outside, dropped
    queue_access(KIND_WRITE, 16'h4321);    // outside, dropped
    queue_access(KIND_WRITE, 16'hBEEF);    // cursor rolled over to column 0
    queue_cmd(CMD_MEM_READ);
    queue_access(KIND_READ, 16'h0000);     // outside: zero, cursor stays
    queue_access(KIND_READ, 16'hFFFF);
    queue_cmd(CMD_OTHER);
    queue_access(KIND_WRITE, 16'hA5A5);    // ignored after other command
    queue_window(CMD_PAGE_SET, 16'(FRAME_H - 1), 16'(FRAME_H));
  endtask

  function automatic idle_phase_t phase_of(int count);
    return idle_phase_t'((count / PHASE_LEN) % 4);
  endfunction

  function automatic bit sender_offers(idle_phase_t ph);
    case (ph)
      PH_SENDER: return $urandom_range(0, 99) >= 54;
      PH_BOTH:   return $urandom_range(0, 99) >= 19;
      default:   return 1'b1;
    endcase
  endfunction

  function automatic bit receiver_stalls(idle_phase_t ph);
    case (ph)
      PH_RECEIVER: return $urandom_range(0, 99) < 54;
      PH_BOTH:     return $urandom_range(0, 99) < 19;
      default:     return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    if (err_count < 100) $display("mismatch: %s", msg);
    err_count++;
  endtask

  // ---- request driver and predictor ----
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_cmd   <= '0;
      in_value <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        cur_access.kind  = in_cmd;
        cur_access.value = in_value;
        expected_q.push_back(model_access(cur_access));
        accepted <= accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        // one pause until the block has returned every result
        if (access_q.size() != 0 && !(issued == DRAIN_AT && expected_q.size() != 0) &&
            sender_offers(phase_of(issued))) begin
          next_access = access_q.pop_front();
          in_valid <= 1'b1;
          in_cmd   <= next_access.kind;
          in_value <= next_access.value;
          issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- result stall, with one long hold-off to fill the block ----
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= receiver_stalls(phase_of(accepted));
    end
  end

  // ---- result monitor ----
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("result with no pending request: read_data %h stored %b",
                                out_read_data, out_pixel_stored));
      end else begin
        want = expected_q.pop_front();
        if (out_read_data !== want.read_data)
          flag_mismatch($sformatf("read_data got %h want %h", out_read_data, want.read_data));
        if (out_pixel_stored !== want.pixel_stored)
          flag_mismatch($sformatf("pixel_stored got %b want %b",
                                  out_pixel_stored, want.pixel_stored));
      end
    end
  end

  // ---- watchdog: cycles with no transfer on either side ----
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    issued      = 0;
    accepted    = 0;
    err_count   = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    idle_cycles = 0;
    reset_model();
    build_directed();
    while (access_q.size() < DIRECTED_MAX + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) queue_burst();
      else if (r < 85) queue_noise($urandom_range(1, 6));
      else queue_broken();
    end
    total_items = access_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted != total_items || expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/lcdw_pkg.sv
design/lcdw_ram.sv
design/lcdw_front.sv
design/lcdw_queue.sv
design/lcdw_back.sv
design/lcd_window_frame_memory.sv
tb/testbench.sv
